[rtl/stlb_pkg.sv]
`timescale 1ns / 1ps

package stlb_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 1024;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   localparam int INDEX_WIDTH = 10;
   localparam int DATA_WIDTH  = 32;
   localparam int COUNT_WIDTH = 11;

   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_SEARCH = 1'b1;

   typedef struct packed {
      logic                          req_type;
      logic [INDEX_WIDTH-1:0]        entry_index;
      logic signed [DATA_WIDTH-1:0]  data_value;
   } search_req_type;

   typedef struct packed {
      logic                   found;
      logic [COUNT_WIDTH-1:0] position;
   } search_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_COMPARE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic write;
      logic load;
      logic step;
      logic result_load;
   } dp_cmd_type;

   typedef struct packed {
      logic range_empty;
   } dp_status_type;

endpackage

[rtl/sorted_table_lower_bound_search.sv]
`timescale 1ns / 1ps

// Channel   Ports                                   Moves
// req       req_valid, req_stall, req_data          write or search request
// rsp       rsp_valid, rsp_stall, rsp_data          search result (found, position)
// csr       csr_write_enable, csr_write_data        element_count register
//
// A write request leaves the block idle. A search request stalls new requests for
// P probes and a finish step, P being at most ceil(log2(n+1)) over n entries;
// each probe is one registered RAM read followed by one compare. Reset clears
// element_count and the control state; table contents stay undefined until written.
// A result held under rsp_stall does not block new requests, but the next search
// waits in its last cycle until that result is taken.

module sorted_table_lower_bound_search #(
   parameter int TABLE_DEPTH = stlb_pkg::TABLE_DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = stlb_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  stlb_pkg::search_req_type         req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output stlb_pkg::search_rsp_type         rsp_data,
   input  logic                             csr_write_enable,
   input  logic [stlb_pkg::COUNT_WIDTH-1:0] csr_write_data
);

   stlb_pkg::dp_cmd_type    cmd;
   stlb_pkg::dp_status_type status;

   stlb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.req_type),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   stlb_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_data         (rsp_data)
   );

endmodule

[rtl/stlb_ram.sv]
`timescale 1ns / 1ps

module stlb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/stlb_ctrl.sv]
`timescale 1ns / 1ps

module stlb_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_kind,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output stlb_pkg::dp_cmd_type    cmd,
   input  stlb_pkg::dp_status_type status
);

   stlb_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stlb_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         stlb_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_kind == stlb_pkg::REQ_SEARCH) begin
                  cmd.load = 1'b1;
                  state_in = stlb_pkg::ST_PROBE;
               end else begin
                  cmd.write = 1'b1;
               end
            end
         end
         stlb_pkg::ST_PROBE: begin
            // read of the midpoint is in flight when the range is not empty
            if (status.range_empty) begin
               state_in = stlb_pkg::ST_FINISH;
            end else begin
               state_in = stlb_pkg::ST_COMPARE;
            end
         end
         stlb_pkg::ST_COMPARE: begin
            cmd.step = 1'b1;
            state_in = stlb_pkg::ST_PROBE;
         end
         stlb_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.result_load = 1'b1;
               state_in        = stlb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = stlb_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.result_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign req_stall = (state_ff != stlb_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/stlb_datapath.sv]
`timescale 1ns / 1ps

module stlb_datapath #(
   parameter int TABLE_DEPTH = stlb_pkg::TABLE_DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = stlb_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  stlb_pkg::search_req_type           req_data,
   input  logic                               csr_write_enable,
   input  logic [stlb_pkg::COUNT_WIDTH-1:0]   csr_write_data,
   input  stlb_pkg::dp_cmd_type               cmd,
   output stlb_pkg::dp_status_type            status,
   output stlb_pkg::search_rsp_type           rsp_data
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = stlb_pkg::COUNT_WIDTH;

   logic [CW-1:0]                 count_ff;
   logic [CW-1:0]                 lo_ff, lo_in;
   logic [CW-1:0]                 hi_ff, hi_in;
   logic [CW-1:0]                 n_ff, n_in;
   logic [CW-1:0]                 mid;
   logic signed [VALUE_WIDTH-1:0] target_ff, target_in;
   logic signed [VALUE_WIDTH-1:0] hi_val_ff, hi_val_in;
   logic signed [VALUE_WIDTH-1:0] req_value;
   logic signed [VALUE_WIDTH-1:0] rd_value;
   logic [VALUE_WIDTH-1:0]        rd_data;
   logic                          wr_en;
   stlb_pkg::search_rsp_type      rsp_ff, rsp_in;

   assign req_value = VALUE_WIDTH'(req_data.data_value);
   assign rd_value  = $signed(rd_data);
   assign mid       = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign wr_en     = cmd.write && (int'(req_data.entry_index) < TABLE_DEPTH);

   stlb_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_data.entry_index)),
      .wr_data (req_value),
      .rd_addr (AW'(mid)),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_write_enable) begin
         count_ff <= csr_write_data;
      end
   end

   always_comb begin
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      n_in      = n_ff;
      target_in = target_ff;
      hi_val_in = hi_val_ff;
      if (cmd.load) begin
         if (int'(count_ff) > TABLE_DEPTH) begin
            n_in = CW'(TABLE_DEPTH);
            hi_in = CW'(TABLE_DEPTH);
         end else begin
            n_in = count_ff;
            hi_in = count_ff;
         end
         lo_in     = '0;
         target_in = req_value;
      end else if (cmd.step) begin
         if (rd_value >= target_ff) begin
            hi_in     = mid;
            hi_val_in = rd_value;
         end else begin
            lo_in = mid + CW'(1);
         end
      end
   end

   // hi below n means hi was set by a probe, so hi_val holds that entry
   always_comb begin
      rsp_in          = rsp_ff;
      if (cmd.result_load) begin
         rsp_in.position = lo_ff;
         rsp_in.found    = (hi_ff < n_ff) && (hi_val_ff == target_ff);
      end
   end

   always_ff @(posedge clock) begin
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      n_ff      <= n_in;
      target_ff <= target_in;
      hi_val_ff <= hi_val_in;
      rsp_ff    <= rsp_in;
   end

   assign status.range_empty = (lo_ff >= hi_ff);
   assign rsp_data           = rsp_ff;

endmodule
